FILE: rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Self-contained; expects the including scope to supply clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is asserted.
`define WRR_ASSERT(name, clk_sig, rst_n, prop, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define WRR_ASSERT_IMPL(name, clk_sig, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WRR_ASSERT_NEXT(name, clk_sig, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wrr_pkg.sv
// Shared types and constants for the weighted round-robin scheduler.
// No dependencies.
package wrr_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int ID_WIDTH_DEF   = 8;
	localparam int PRIO_WIDTH_DEF = 4;
	localparam int OP_W           = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

endpackage

FILE: rtl/wrr_if.sv
// Valid/ready channel interfaces for scheduler commands and status beats.
// Depends on wrr_pkg.
interface wrr_cmd_if #(
	parameter int ID_WIDTH   = wrr_pkg::ID_WIDTH_DEF,
	parameter int PRIO_WIDTH = wrr_pkg::PRIO_WIDTH_DEF
);
	logic                      valid;
	logic                      ready;
	logic [wrr_pkg::OP_W-1:0]  opcode;
	logic [ID_WIDTH-1:0]       task_id;
	logic [PRIO_WIDTH-1:0]     priority_req;

	modport source (output valid, opcode, task_id, priority_req, input ready);
	modport sink   (input valid, opcode, task_id, priority_req, output ready);
endinterface

interface wrr_res_if #(
	parameter int ID_WIDTH  = wrr_pkg::ID_WIDTH_DEF,
	parameter int CNT_WIDTH = $clog2(wrr_pkg::DEPTH_DEF + 1)
);
	logic                 valid;
	logic                 ready;
	logic                 current_valid;
	logic [ID_WIDTH-1:0]  current_task;
	logic [CNT_WIDTH-1:0] entry_count;
	logic                 insert_dropped;

	modport source (output valid, current_valid, current_task, entry_count, insert_dropped,
		input ready);
	modport sink   (input valid, current_valid, current_task, entry_count, insert_dropped,
		output ready);
endinterface

FILE: rtl/weighted_round_robin_scheduler.sv
// Weighted round-robin scheduler: one command beat in, one status beat out.
// Depends on wrr_pkg, wrr_if.sv (wrr_cmd_if, wrr_res_if) and assert_macros.svh.
//
// The block takes one command beat every cycle, unless a full input register waits on a
// stalled output side, and returns one status beat per command. A command sits in an
// input register, one pass of slot-update logic resolves it, and the status lands in an
// output register; the input register refills while a status beat waits, so a stall on
// the output side costs nothing until both registers are full. The ring is a row of
// DEPTH slots held so that slot 0 is always the current task and slots 0..count-1 are in
// scheduling order: insert writes slot count, remove shifts every slot down by one, and a
// quantum expiry shifts down and drops the old current task into slot count-1. Each slot
// thus looks only at its neighbor, slot 0, the count and the command, which is what sets
// the one beat per cycle rate at any depth. The tick counter survives a remove. The ring
// slots need no reset and no clearing pass; only the count, the counter and the handshake
// state are cleared by arst_n.
`include "assert_macros.svh"

module weighted_round_robin_scheduler #(
	parameter int DEPTH      = wrr_pkg::DEPTH_DEF,
	parameter int ID_WIDTH   = wrr_pkg::ID_WIDTH_DEF,
	parameter int PRIO_WIDTH = wrr_pkg::PRIO_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wrr_cmd_if.sink    cmd,
	wrr_res_if.source  res
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	// quantum is priority+1, so it needs one bit more than the priority
	localparam int TICK_W = PRIO_WIDTH + 1;

	typedef struct packed {
		logic [ID_WIDTH-1:0] id;
		logic [TICK_W-1:0]   quantum;
	} slot_t;

	// input stage
	logic                  s1_valid_q;
	wrr_pkg::op_t          op_s1;
	logic [ID_WIDTH-1:0]   id_s1;
	logic [PRIO_WIDTH-1:0] prio_s1;

	// scheduler state
	slot_t                 ring_q [DEPTH];
	slot_t                 ring_d [DEPTH];
	logic [CNT_W-1:0]      occ_q, occ_d;
	logic [TICK_W-1:0]     tick_q, tick_d;
	logic [TICK_W-1:0]     tick_inc;

	// output register
	logic                  res_valid_q;
	logic                  cur_valid_q;
	logic [ID_WIDTH-1:0]   cur_task_q;
	logic [CNT_W-1:0]      count_q;
	logic                  dropped_q;

	logic                  res_adv;
	logic                  fire;
	logic                  do_shift;
	logic                  do_rotate;
	logic                  do_insert;
	logic                  dropped;
	slot_t                 new_slot;

	// The output register frees up when empty or when its beat is taken.
	assign res_adv   = !res_valid_q || res.ready;
	assign fire      = s1_valid_q && res_adv;
	assign cmd.ready = !s1_valid_q || res_adv;

	// Capture the command beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1   <= wrr_pkg::op_t'(cmd.opcode);
			id_s1   <= cmd.task_id;
			prio_s1 <= cmd.priority_req;
		end
	end

	assign tick_inc = tick_q + TICK_W'(1);
	assign new_slot = '{id: id_s1, quantum: TICK_W'(prio_s1) + TICK_W'(1)};

	// Decode the command against the current count and counter.
	always_comb begin
		occ_d     = occ_q;
		tick_d    = tick_q;
		do_shift  = 1'b0;
		do_rotate = 1'b0;
		do_insert = 1'b0;
		dropped   = 1'b0;
		if (fire) begin
			unique case (op_s1)
				wrr_pkg::OP_INSERT: begin
					if (occ_q == CNT_W'(DEPTH)) begin
						// ring full: drop and flag
						dropped = 1'b1;
					end else begin
						do_insert = 1'b1;
						occ_d     = occ_q + CNT_W'(1);
						// first task starts a fresh quantum
						if (occ_q == '0) begin
							tick_d = '0;
						end
					end
				end
				wrr_pkg::OP_REMOVE: begin
					// counter is kept across a remove
					if (occ_q != '0) begin
						do_shift = 1'b1;
						occ_d    = occ_q - CNT_W'(1);
					end
				end
				wrr_pkg::OP_TICK: begin
					if (occ_q != '0) begin
						if (tick_inc >= ring_q[0].quantum) begin
							// quantum spent: current task goes to the tail
							tick_d    = '0;
							do_shift  = 1'b1;
							do_rotate = 1'b1;
						end else begin
							tick_d = tick_inc;
						end
					end
				end
				wrr_pkg::OP_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Per-slot update: hold, take the upper neighbor, take the old head, or take the new task.
	for (genvar g = 0; g < DEPTH; g++) begin : g_slot
		slot_t upper;
		if (g == DEPTH - 1) begin : g_wrap
			assign upper = ring_q[0];
		end else begin : g_mid
			assign upper = ring_q[g+1];
		end

		always_comb begin
			ring_d[g] = ring_q[g];
			if (do_shift) begin
				ring_d[g] = upper;
			end
			if (do_rotate && (CNT_W'(g) == occ_q - CNT_W'(1))) begin
				ring_d[g] = ring_q[0];
			end
			if (do_insert && (CNT_W'(g) == occ_q)) begin
				ring_d[g] = new_slot;
			end
		end
	end

	always_ff @(posedge clk) begin
		ring_q <= ring_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			tick_q <= '0;
		end else begin
			occ_q  <= occ_d;
			tick_q <= tick_d;
		end
	end

	// Status beat reflects the state after the command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_adv) begin
			res_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cur_valid_q <= (occ_d != '0);
			cur_task_q  <= (occ_d != '0) ? ring_d[0].id : '0;
			count_q     <= occ_d;
			dropped_q   <= dropped;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.current_valid  = cur_valid_q;
	assign res.current_task   = cur_task_q;
	assign res.entry_count    = count_q;
	assign res.insert_dropped = dropped_q;

	`WRR_ASSERT(a_occ_bound, clk, arst_n, occ_q <= CNT_W'(DEPTH), "occupancy above depth")
	`WRR_ASSERT(a_tick_bound, clk, arst_n, tick_q < (TICK_W'(1) << PRIO_WIDTH), "tick counter past largest quantum")
	`WRR_ASSERT_NEXT(a_drop_flag, clk, arst_n, fire && op_s1 == wrr_pkg::OP_INSERT && occ_q == CNT_W'(DEPTH), res.insert_dropped, "insert into full ring not flagged")
	`WRR_ASSERT_IMPL(a_cur_valid, clk, arst_n, res.valid, res.current_valid == (res.entry_count != '0), "current_valid disagrees with count")

endmodule

FILE: test/weighted_round_robin_scheduler_tb.sv
// Self-checking testbench for the weighted round-robin scheduler.
// Depends on wrr_pkg, wrr_if.sv (wrr_cmd_if, wrr_res_if) and the scheduler RTL.
// Predicts every status beat from an in-order run queue and checks it field by field.
module weighted_round_robin_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = wrr_pkg::DEPTH_DEF;
	localparam int ID_W        = wrr_pkg::ID_WIDTH_DEF;
	localparam int PRIO_W      = wrr_pkg::PRIO_WIDTH_DEF;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int QUANTUM_W   = PRIO_W + 1;
	// Cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT = 1000;
	// Cycles to watch for stray beats once nothing is expected.
	localparam int TAIL_CYCLES = 8;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic              current_valid;
		logic [ID_W-1:0]   current_task;
		logic [CNT_W-1:0]  entry_count;
		logic              insert_dropped;
	} status_t;

	typedef struct {
		logic [ID_W-1:0]      id;
		logic [QUANTUM_W-1:0] quantum;
	} run_entry_t;

	logic clk;
	logic arst_n;

	wrr_cmd_if #(.ID_WIDTH(ID_W), .PRIO_WIDTH(PRIO_W)) cmd_ch ();
	wrr_res_if #(.ID_WIDTH(ID_W), .CNT_WIDTH(CNT_W))   res_ch ();

	weighted_round_robin_scheduler #(
		.DEPTH      (DEPTH),
		.ID_WIDTH   (ID_W),
		.PRIO_WIDTH (PRIO_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	// Predicted scheduler state: the run queue holds the tasks in scheduling
	// order, front is the current task, back is the tail.
	run_entry_t           run_queue[$];
	logic [QUANTUM_W-1:0] quantum_ticks;

	// Status beats predicted but not yet seen on the result channel.
	status_t status_backlog[$];
	int      mismatch_count;

	// Sender pacing: bursts of up to burst_max beats, gaps of up to gap_max
	// cycles between them; gap_max of zero means back-to-back beats.
	int unsigned burst_left;
	int unsigned burst_max;
	int unsigned gap_max;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance the predicted state by one command and return the status beat
	// it must produce.
	function automatic status_t apply_command(input wrr_pkg::op_t op,
		input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio);
		status_t    st;
		run_entry_t ent;
		st.insert_dropped = 1'b0;
		case (op)
			wrr_pkg::OP_INSERT: begin
				if (run_queue.size() >= DEPTH) begin
					// full ring: refuse and flag, state untouched
					st.insert_dropped = 1'b1;
				end else begin
					// first task into an empty ring starts a fresh quantum
					if (run_queue.size() == 0)
						quantum_ticks = '0;
					ent.id      = id;
					ent.quantum = QUANTUM_W'(prio) + QUANTUM_W'(1);
					run_queue.push_back(ent);
				end
			end
			wrr_pkg::OP_REMOVE: begin
				// the tick counter carries over to the next task
				if (run_queue.size() != 0)
					ent = run_queue.pop_front();
			end
			wrr_pkg::OP_TICK: begin
				if (run_queue.size() != 0) begin
					quantum_ticks = quantum_ticks + QUANTUM_W'(1);
					if (quantum_ticks >= run_queue[0].quantum) begin
						// quantum spent: move the current task to the tail
						quantum_ticks = '0;
						ent = run_queue.pop_front();
						run_queue.push_back(ent);
					end
				end
			end
			default: ;
		endcase
		st.current_valid = (run_queue.size() != 0);
		st.current_task  = (run_queue.size() != 0) ? run_queue[0].id : '0;
		st.entry_count   = CNT_W'(run_queue.size());
		return st;
	endfunction

	// Present one command beat, hold it until accepted, then log its status.
	// Valid stays high on return so the next beat can follow back to back.
	task automatic send_command(input wrr_pkg::op_t op, input logic [ID_W-1:0] id,
		input logic [PRIO_W-1:0] prio);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, burst_max);
		end
		burst_left--;
		cmd_ch.valid        <= 1'b1;
		cmd_ch.opcode       <= op;
		cmd_ch.task_id      <= id;
		cmd_ch.priority_req <= prio;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		status_backlog.push_back(apply_command(op, id, prio));
	endtask

	// Drop valid and hold off until every predicted status beat has arrived.
	task automatic drain_status;
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (status_backlog.size() != 0)
			@(posedge clk);
	endtask

	function automatic wrr_pkg::op_t pick_op(input int unsigned w_ins,
		input int unsigned w_rem, input int unsigned w_tick, input int unsigned w_nop);
		int unsigned r;
		r = $urandom_range(0, w_ins + w_rem + w_tick + w_nop - 1);
		if (r < w_ins)
			return wrr_pkg::OP_INSERT;
		if (r < w_ins + w_rem)
			return wrr_pkg::OP_REMOVE;
		if (r < w_ins + w_rem + w_tick)
			return wrr_pkg::OP_TICK;
		return wrr_pkg::OP_NOP;
	endfunction

	// Random command stream with the given opcode weights. Ids and priorities
	// are random on every beat, also where the opcode ignores them; short_quanta
	// keeps most priorities low so quanta expire often.
	task automatic run_traffic(input int n, input int unsigned w_ins, input int unsigned w_rem,
		input int unsigned w_tick, input int unsigned w_nop, input bit short_quanta);
		logic [PRIO_W-1:0] prio;
		for (int i = 0; i < n; i++) begin
			if (short_quanta && ($urandom_range(0, 3) != 0))
				prio = PRIO_W'($urandom_range(0, 2));
			else
				prio = PRIO_W'($urandom);
			send_command(pick_op(w_ins, w_rem, w_tick, w_nop), ID_W'($urandom), prio);
		end
	endtask

	// Empty ring: tick, remove and no-op leave everything alone; then the
	// first insert becomes current with the largest id and priority.
	task automatic test_empty_ring;
		gap_max   = 0;
		burst_max = 4;
		send_command(wrr_pkg::OP_TICK,   '1, '1);
		send_command(wrr_pkg::OP_REMOVE, '1, '1);
		send_command(wrr_pkg::OP_NOP,    '0, '0);
		send_command(wrr_pkg::OP_INSERT, '1, '1);
		send_command(wrr_pkg::OP_NOP,    '1, '1);
	endtask

	// Quantum handling: a counter that survives a remove makes the next
	// task's one-tick quantum expire on its first tick.
	task automatic test_quantum_carry;
		gap_max   = 2;
		burst_max = 3;
		send_command(wrr_pkg::OP_INSERT, ID_W'(8'h11), PRIO_W'(4'h3));
		send_command(wrr_pkg::OP_INSERT, ID_W'(8'h22), '0);
		send_command(wrr_pkg::OP_TICK,   '0, '0);
		send_command(wrr_pkg::OP_TICK,   '0, '0);
		send_command(wrr_pkg::OP_REMOVE, '0, '0);
		send_command(wrr_pkg::OP_TICK,   '0, '0);
		send_command(wrr_pkg::OP_TICK,   '0, '0);
		send_command(wrr_pkg::OP_INSERT, ID_W'(8'hA5), PRIO_W'(4'h5));
	endtask

	// Full ring: fill every slot, see the extra insert refused, then make
	// room again with a remove.
	task automatic test_full_ring;
		int k;
		gap_max   = 1;
		burst_max = 6;
		k = 0;
		while (run_queue.size() < DEPTH) begin
			send_command(wrr_pkg::OP_INSERT, ID_W'(8'h5A ^ (k * 8'h13)), PRIO_W'(k));
			k++;
		end
		send_command(wrr_pkg::OP_INSERT, ID_W'(8'hC3), PRIO_W'(4'hA));
		send_command(wrr_pkg::OP_REMOVE, '0, '0);
	endtask

	// Insert-heavy stream: spend long stretches at a full ring.
	task automatic test_fill_pressure;
		gap_max   = 6;
		burst_max = 8;
		run_traffic(160, 60, 10, 25, 5, 1'b0);
	endtask

	// Remove-heavy stream: keep hitting the empty ring and refilling it.
	task automatic test_drain_pressure;
		gap_max   = 3;
		burst_max = 5;
		run_traffic(160, 30, 45, 20, 5, 1'b0);
	endtask

	// Tick-heavy stream with short quanta: many rotations and carried counters.
	task automatic test_quantum_expiry;
		gap_max   = 0;
		burst_max = 16;
		run_traffic(220, 22, 12, 62, 4, 1'b1);
	endtask

	// Balanced stream with long sender gaps.
	task automatic test_mixed_traffic;
		gap_max   = 10;
		burst_max = 12;
		run_traffic(160, 35, 25, 35, 5, 1'b0);
	endtask

	// Receiver stall pattern: switch at random intervals between always
	// ready, random stalls, a periodic two-in-five stall and long stalls.
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	int unsigned stall_phase = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode  = $urandom_range(0, 3);
			stall_left  = $urandom_range(20, 80);
			stall_phase = 0;
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 9) < 7);
			2: res_ch.ready <= ((stall_phase % 5) > 1);
			default: res_ch.ready <= ((stall_phase % 20) >= 12);
		endcase
	end

	// Check each accepted status beat against the oldest prediction.
	always @(posedge clk) begin
		status_t want;
		status_t got;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.current_valid  = res_ch.current_valid;
			got.current_task   = res_ch.current_task;
			got.entry_count    = res_ch.entry_count;
			got.insert_dropped = res_ch.insert_dropped;
			if (status_backlog.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("[%0t] unexpected status beat: valid=%0b task=%0d count=%0d drop=%0b",
						$realtime, got.current_valid, got.current_task, got.entry_count,
						got.insert_dropped);
			end else begin
				want = status_backlog.pop_front();
				if (got.current_valid !== want.current_valid
						|| got.current_task !== want.current_task
						|| got.entry_count !== want.entry_count
						|| got.insert_dropped !== want.insert_dropped) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("[%0t] status mismatch: exp valid=%0b task=%0d count=%0d drop=%0b",
							$realtime, want.current_valid, want.current_task,
							want.entry_count, want.insert_dropped,
							", got valid=%0b task=%0d count=%0d drop=%0b",
							got.current_valid, got.current_task, got.entry_count,
							got.insert_dropped);
				end
			end
		end
	end

	// Watchdog: end the run once no beat has moved for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
					|| (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		// Drive every input to a known value from time zero.
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.opcode       = wrr_pkg::OP_NOP;
		cmd_ch.task_id      = '0;
		cmd_ch.priority_req = '0;
		res_ch.ready        = 1'b0;
		mismatch_count      = 0;
		quantum_ticks       = '0;
		burst_left          = 0;
		burst_max           = 1;
		gap_max             = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_ring();
		test_quantum_carry();
		test_full_ring();
		// Hold the sender until every status beat is back before going random.
		drain_status();
		test_fill_pressure();
		test_drain_pressure();
		drain_status();
		test_quantum_expiry();
		test_mixed_traffic();

		// Wait out the backlog, then keep watching for stray beats before the verdict.
		drain_status();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && status_backlog.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wrr_pkg.sv
rtl/wrr_if.sv
rtl/weighted_round_robin_scheduler.sv
test/weighted_round_robin_scheduler_tb.sv
